### rtl/gbs_pkg.sv
// Shared types and constants for the grid bilinear sampler.
// Used by gbs_renorm and grid_bilinear_pos_normal_sampler_core.
package gbs_pkg;

  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [0:0]  REG_GRID_SIZE = 1'b0;
  localparam logic [8:0]  GRID_SIZE_RST = 9'd256;
  localparam logic [0:0]  REQ_LOAD = 1'b0;
  localparam logic [0:0]  REQ_QUERY = 1'b1;
  localparam logic [15:0] NRM_ONE = 16'd16384;

  // Rounded blend results handed to the normalizer.
  typedef struct packed {
    logic [2:0][15:0] pos;
    logic [2:0][30:0] nc;
  } job_t;

  typedef struct packed {
    logic [2:0][15:0] pos;
    logic [2:0][15:0] nrm;
  } res_t;

  typedef enum logic [5:0] {
    RN_IDLE = 6'b000001,
    RN_SQ   = 6'b000010,
    RN_SUM  = 6'b000100,
    RN_ROOT = 6'b001000,
    RN_DIV  = 6'b010000,
    RN_DONE = 6'b100000
  } rn_state_e;

endpackage

### rtl/gbs_renorm.sv
// Normal renormalizer: squared length, bit-serial integer root, three
// parallel restoring dividers. Depends on gbs_pkg.
module gbs_renorm (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  gbs_pkg::job_t job_i,
  output logic          job_ready_o,
  output logic          res_valid_o,
  output gbs_pkg::res_t res_o,
  input  logic          res_take_i
);
  import gbs_pkg::*;

  localparam int NW = 62;
  localparam int RW = 46;

  rn_state_e         st_q, st_d;
  job_t              job_q;
  logic [29:0]       a_q [3];
  logic [59:0]       sq_q [3];
  logic [NW-1:0]     n_q, res_q, bit_q;
  logic [30:0]       len_q;
  logic [RW-1:0]     rem_q [3];
  logic [RW-1:0]     dv_q;
  logic [14:0]       q_q [3];
  logic [3:0]        cnt_q;
  logic [NW-1:0]     trial;

  assign trial = res_q + bit_q;
  assign job_ready_o = (st_q == RN_IDLE);
  assign res_valid_o = (st_q == RN_DONE);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      RN_IDLE: if (job_valid_i) st_d = RN_SQ;
      RN_SQ:   st_d = RN_SUM;
      RN_SUM:  st_d = RN_ROOT;
      RN_ROOT: if (bit_q == '0) st_d = RN_DIV;
      RN_DIV:  if (cnt_q == 4'd14) st_d = RN_DONE;
      RN_DONE: if (res_take_i) st_d = RN_IDLE;
      default: st_d = RN_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= RN_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      RN_IDLE: begin
        if (job_valid_i) begin
          job_q <= job_i;
          for (int k = 0; k < 3; k++) begin
            a_q[k] <= job_i.nc[k][30] ? 30'(-signed'(job_i.nc[k])) : job_i.nc[k][29:0];
          end
        end
      end
      RN_SQ: begin
        for (int k = 0; k < 3; k++) sq_q[k] <= 60'(a_q[k]) * 60'(a_q[k]);
      end
      RN_SUM: begin
        n_q   <= NW'(sq_q[0]) + NW'(sq_q[1]) + NW'(sq_q[2]);
        res_q <= '0;
        bit_q <= NW'(1) << 60;
      end
      RN_ROOT: begin
        if (bit_q != '0) begin
          if (n_q >= trial) begin
            n_q   <= n_q - trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end else begin
          len_q <= res_q[30:0];
          dv_q  <= RW'(res_q[30:0]) << 14;
          cnt_q <= '0;
          for (int k = 0; k < 3; k++) begin
            rem_q[k] <= (RW'(a_q[k]) << 14) + RW'(res_q[30:1]);
            q_q[k]   <= '0;
          end
        end
      end
      RN_DIV: begin
        for (int k = 0; k < 3; k++) begin
          if (rem_q[k] >= dv_q) begin
            rem_q[k] <= rem_q[k] - dv_q;
            q_q[k]   <= {q_q[k][13:0], 1'b1};
          end else begin
            q_q[k]   <= {q_q[k][13:0], 1'b0};
          end
        end
        dv_q  <= dv_q >> 1;
        cnt_q <= cnt_q + 4'd1;
      end
      RN_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    logic [15:0] mag;
    res_o.pos = job_q.pos;
    for (int k = 0; k < 3; k++) begin
      mag = ({1'b0, q_q[k]} > NRM_ONE) ? NRM_ONE : {1'b0, q_q[k]};
      if (len_q == '0) begin
        res_o.nrm[k] = '0;
      end else begin
        res_o.nrm[k] = job_q.nc[k][30] ? 16'(-mag) : mag;
      end
    end
  end

endmodule

### rtl/grid_bilinear_pos_normal_sampler_core.sv
// Grid sampler with bilinear position and normal interpolation.
// Depends on gbs_pkg and gbs_renorm.
//
// A load beat writes one grid entry. A query beat reads its four cell
// corners, one after another, from the single-ported position and normal
// memories, and loads stall during those reads. A second query waits until
// the first has been handed to the normalizer. The normalizer (squares,
// 31-step bit-serial root, 15-step divide) works on one query at a time
// and takes no new one until its result is taken; loads and a following
// query's corner reads overlap with it. A query's result passes the blend
// pipeline, the hold register, the normalizer and the output register.
// Stores are undefined until written.
module grid_bilinear_pos_normal_sampler_core #(
  parameter int GRID_MAX = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [7:0]         grid_col_i,
  input  logic [7:0]         grid_row_i,
  input  logic signed [15:0] vert_x_i,
  input  logic signed [15:0] vert_y_i,
  input  logic signed [15:0] vert_z_i,
  input  logic signed [15:0] nrm_x_i,
  input  logic signed [15:0] nrm_y_i,
  input  logic signed [15:0] nrm_z_i,
  input  logic [16:0]        query_u_i,
  input  logic [16:0]        query_v_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] out_pos_x_o,
  output logic signed [15:0] out_pos_y_o,
  output logic signed [15:0] out_pos_z_o,
  output logic signed [15:0] out_nrm_x_o,
  output logic signed [15:0] out_nrm_y_o,
  output logic signed [15:0] out_nrm_z_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import gbs_pkg::*;

  localparam int CW = $clog2(GRID_MAX);
  localparam int DEPTH = GRID_MAX * GRID_MAX;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = ($clog2(GRID_MAX + 1) > 9) ? $clog2(GRID_MAX + 1) : 9;
  localparam int TW = 17 + SW;

  // ---------------- configuration ----------------
  logic [8:0] grid_size_q;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_GRID_SIZE) ? {23'd0, grid_size_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GRID_SIZE_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_GRID_SIZE) begin
      grid_size_q <= pwdata[8:0];
    end
  end

  logic [SW-1:0] size_g, size_eff;
  assign size_g = SW'(grid_size_q);
  always_comb begin
    if (size_g < SW'(2)) size_eff = SW'(2);
    else if (size_g > SW'(GRID_MAX)) size_eff = SW'(GRID_MAX);
    else size_eff = size_g;
  end

  function automatic logic [CW+16:0] split(input logic [16:0] q, input logic [SW-1:0] sz);
    logic [TW-1:0] t, d;
    logic [SW:0]   i, lim;
    t   = TW'(q) * TW'(sz - SW'(1));
    i   = t[TW-1:16];
    lim = (SW+1)'(sz) - (SW+1)'(2);
    if (i > lim) i = lim;
    d = t - (TW'(i) << 16);
    return {CW'(i), d[16:0]};
  endfunction

  function automatic logic [AW-1:0] corner_addr(input logic [CW-1:0] ix,
                                                input logic [CW-1:0] iz,
                                                input logic [1:0] p);
    logic [CW-1:0] c, r;
    c = ix + CW'(p[0]);
    r = iz + CW'(p[1]);
    return AW'(r) * AW'(GRID_MAX) + AW'(c);
  endfunction

  // ---------------- accept and corner issue ----------------
  logic          busy_q, token_q;
  logic [1:0]    phase_q;
  logic [CW-1:0] ix_q, iz_q;
  logic [16:0]   fx_q, fz_q;
  logic          in_acc, q_ok, q_acc, wr_en, rd_en;
  logic [CW+16:0] su, sv;
  logic [AW-1:0] mem_addr;
  logic          hold_v_q, job_ready;

  assign q_ok  = (req_type_i == REQ_QUERY) && query_u_i <= ONE_Q16 && query_v_i <= ONE_Q16;
  assign in_stall_o = busy_q || (in_valid_i && q_ok && token_q);
  assign in_acc = in_valid_i && !in_stall_o;
  assign q_acc  = in_acc && q_ok;
  assign wr_en  = in_acc && req_type_i == REQ_LOAD &&
                  int'(grid_col_i) < GRID_MAX && int'(grid_row_i) < GRID_MAX;
  assign rd_en  = q_acc || busy_q;
  assign su = split(query_u_i, size_eff);
  assign sv = split(query_v_i, size_eff);

  always_comb begin
    if (q_acc) mem_addr = corner_addr(su[CW+16:17], sv[CW+16:17], 2'd0);
    else if (busy_q) mem_addr = corner_addr(ix_q, iz_q, phase_q);
    else mem_addr = AW'(grid_row_i) * AW'(GRID_MAX) + AW'(grid_col_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= '0;
      token_q <= 1'b0;
    end else begin
      if (q_acc) begin
        busy_q  <= 1'b1;
        phase_q <= 2'd1;
      end else if (busy_q) begin
        phase_q <= phase_q + 2'd1;
        if (phase_q == 2'd3) busy_q <= 1'b0;
      end
      if (q_acc) token_q <= 1'b1;
      else if (hold_v_q && job_ready) token_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_acc) begin
      ix_q <= su[CW+16:17];
      fx_q <= su[16:0];
      iz_q <= sv[CW+16:17];
      fz_q <= sv[16:0];
    end
  end

  // ---------------- stores ----------------
  logic [47:0] pos_mem [DEPTH];
  logic [47:0] nrm_mem [DEPTH];
  logic [47:0] pos_rd_q, nrm_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pos_mem[mem_addr] <= {vert_z_i, vert_y_i, vert_x_i};
    end else if (rd_en) begin
      pos_rd_q <= pos_mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      nrm_mem[mem_addr] <= {nrm_z_i, nrm_y_i, nrm_x_i};
    end else if (rd_en) begin
      nrm_rd_q <= nrm_mem[mem_addr];
    end
  end

  // ---------------- blend pipeline ----------------
  logic              s1_v_q, s2_v_q, s3_v_q, fin_v_q;
  logic [1:0]        s1_p_q, s2_p_q, s3_p_q;
  logic [32:0]       w2_q;
  logic signed [15:0] d2_q [6];
  logic signed [49:0] prod_q [6];
  logic signed [49:0] acc_q [6];
  logic [16:0]       wx, wz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      fin_v_q <= 1'b0;
    end else begin
      s1_v_q  <= rd_en;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      fin_v_q <= s3_v_q && s3_p_q == 2'd3;
    end
  end

  assign wx = s1_p_q[0] ? fx_q : 17'(ONE_Q16 - fx_q);
  assign wz = s1_p_q[1] ? fz_q : 17'(ONE_Q16 - fz_q);

  always_ff @(posedge clk_i) begin
    s1_p_q <= q_acc ? 2'd0 : phase_q;
    s2_p_q <= s1_p_q;
    s3_p_q <= s2_p_q;
    w2_q   <= 33'(34'(wx) * 34'(wz));
    for (int k = 0; k < 3; k++) begin
      d2_q[k]   <= pos_rd_q[16*k +: 16];
      d2_q[k+3] <= nrm_rd_q[16*k +: 16];
    end
    for (int k = 0; k < 6; k++) begin
      prod_q[k] <= 50'(d2_q[k] * signed'({1'b0, w2_q}));
      if (s3_p_q == 2'd0) acc_q[k] <= prod_q[k];
      else acc_q[k] <= acc_q[k] + prod_q[k];
    end
  end

  // ---------------- rounding and handoff ----------------
  job_t        hold_q;
  logic [2:0][15:0] pos_r;
  logic [2:0][30:0] nc_r;

  always_comb begin
    logic signed [49:0] t;
    logic signed [17:0] p;
    for (int k = 0; k < 3; k++) begin
      t = acc_q[k] + (50'sd1 <<< 31);
      p = 18'(t >>> 32);
      if (p > 18'sd32767) pos_r[k] = 16'h7FFF;
      else if (p < -18'sd32768) pos_r[k] = 16'h8000;
      else pos_r[k] = p[15:0];
      t = acc_q[k+3] + (50'sd1 <<< 17);
      nc_r[k] = 31'(t >>> 18);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
    end else if (fin_v_q) begin
      hold_v_q <= 1'b1;
    end else if (job_ready) begin
      hold_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_v_q) begin
      hold_q.pos <= pos_r;
      hold_q.nc  <= nc_r;
    end
  end

  logic   res_valid, res_take;
  res_t   res;

  gbs_renorm u_renorm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (hold_v_q),
    .job_i       (hold_q),
    .job_ready_o (job_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  // ---------------- output register ----------------
  logic out_v_q;
  res_t out_q;
  assign res_take = res_valid && (!out_v_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (res_take) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) out_q <= res;
  end

  assign out_valid_o = out_v_q;
  assign out_pos_x_o = out_q.pos[0];
  assign out_pos_y_o = out_q.pos[1];
  assign out_pos_z_o = out_q.pos[2];
  assign out_nrm_x_o = out_q.nrm[0];
  assign out_nrm_y_o = out_q.nrm[1];
  assign out_nrm_z_o = out_q.nrm[2];

  // ---------------- checks ----------------
  a_busy_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> token_q) else $error("corner reads without a query token");

  a_hold_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_v_q |-> !hold_v_q) else $error("blend result overwrote held job");

  a_port_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && busy_q)) else $error("store write during corner reads");

endmodule
